/* sv/tsb_pkg.sv */
package tsb_pkg;

    localparam int SLOTS      = 16;
    localparam int MAX_EVENTS = 16;
    localparam int SLOT_CNT   = (SLOTS < MAX_EVENTS) ? SLOTS : MAX_EVENTS;
    localparam int IDX_W      = (SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1;

    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int SEC_W    = 8;
    localparam int MSEC_W   = 16;
    localparam int TIME_W   = 64;
    localparam int PERIOD_W = 39;

    localparam int NS_PER_SEC_W  = 30;
    localparam int NS_PER_MSEC_W = 20;
    localparam int SEC_PROD_W    = SEC_W + NS_PER_SEC_W;
    localparam int MSEC_PROD_W   = MSEC_W + NS_PER_MSEC_W;

    localparam logic [NS_PER_SEC_W-1:0]  NS_PER_SEC  = 30'd1000000000;
    localparam logic [NS_PER_MSEC_W-1:0] NS_PER_MSEC = 20'd1000000;

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_STOP,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [SLOT_W-1:0]     slot;
        logic                  periodic;
        logic [PERIOD_W-1:0]   period;
        logic [TIME_W-1:0]     now;
    } cmd_t;

endpackage

/* sv/tsb_front.sv */
module tsb_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [tsb_pkg::MODE_W-1:0]        mode,
    input  logic [tsb_pkg::SLOT_W-1:0]        slot,
    input  logic [tsb_pkg::SEC_W-1:0]         seconds,
    input  logic [tsb_pkg::MSEC_W-1:0]        milliseconds,
    input  logic                              periodic,
    input  logic [tsb_pkg::TIME_W-1:0]        now,
    output logic                              q_push,
    output tsb_pkg::cmd_t                     q_cmd,
    input  logic                              q_full
);

    logic                                  stage_valid_reg;
    tsb_pkg::cmd_kind_t                    kind_reg;
    logic [tsb_pkg::SLOT_W-1:0]            slot_reg;
    logic                                  periodic_reg;
    logic [tsb_pkg::SEC_PROD_W-1:0]        sec_prod_reg;
    logic [tsb_pkg::MSEC_PROD_W-1:0]       msec_prod_reg;
    logic [tsb_pkg::TIME_W-1:0]            now_reg;

    tsb_pkg::cmd_kind_t                    kind;
    logic                                  in_range;
    logic                                  usable;
    logic                                  accept;
    logic                                  keep;

    assign full     = stage_valid_reg && q_full;
    assign accept   = push && !full;
    assign in_range = ({1'b0, slot} < (tsb_pkg::SLOT_W + 1)'(tsb_pkg::SLOT_CNT));

    // classify the request; unused mode and out-of-range slots are dropped here
    always_comb
    begin
        kind   = tsb_pkg::CMD_TICK;
        usable = 1'b0;
        unique case (mode)
            tsb_pkg::MODE_START:
            begin
                kind   = tsb_pkg::CMD_START;
                usable = in_range;
            end
            tsb_pkg::MODE_STOP:
            begin
                kind   = tsb_pkg::CMD_STOP;
                usable = in_range;
            end
            tsb_pkg::MODE_TICK:
            begin
                kind   = tsb_pkg::CMD_TICK;
                usable = 1'b1;
            end
            default:
            begin
                kind   = tsb_pkg::CMD_TICK;
                usable = 1'b0;
            end
        endcase
    end

    assign keep = accept && usable;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!full)
        begin
            stage_valid_reg <= keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            kind_reg      <= kind;
            slot_reg      <= slot;
            periodic_reg  <= periodic;
            now_reg       <= now;
            sec_prod_reg  <= tsb_pkg::SEC_PROD_W'(seconds)
                             * tsb_pkg::SEC_PROD_W'(tsb_pkg::NS_PER_SEC);
            msec_prod_reg <= tsb_pkg::MSEC_PROD_W'(milliseconds)
                             * tsb_pkg::MSEC_PROD_W'(tsb_pkg::NS_PER_MSEC);
        end
    end

    assign q_push = stage_valid_reg && !q_full;

    always_comb
    begin
        q_cmd.kind     = kind_reg;
        q_cmd.slot     = slot_reg;
        q_cmd.periodic = periodic_reg;
        q_cmd.period   = tsb_pkg::PERIOD_W'(sec_prod_reg)
                         + tsb_pkg::PERIOD_W'(msec_prod_reg);
        q_cmd.now      = now_reg;
    end

endmodule

/* sv/tsb_queue.sv */
module tsb_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  tsb_pkg::cmd_t     wr_data,
    output logic              full,
    input  logic              rd_en,
    output tsb_pkg::cmd_t     rd_data,
    output logic              empty
);

    tsb_pkg::cmd_t                   mem [tsb_pkg::QUEUE_DEPTH];
    logic [tsb_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [tsb_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [tsb_pkg::QCNT_W-1:0]      count_reg;
    logic [tsb_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [tsb_pkg::QPTR_W-1:0]      rd_ptr_next;

    localparam logic [tsb_pkg::QPTR_W-1:0] LAST_PTR = tsb_pkg::QPTR_W'(tsb_pkg::QUEUE_DEPTH - 1);
    localparam logic [tsb_pkg::QCNT_W-1:0] DEPTH_CNT = tsb_pkg::QCNT_W'(tsb_pkg::QUEUE_DEPTH);

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count beyond depth");

endmodule

/* sv/tsb_back.sv */
module tsb_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tsb_pkg::cmd_t                 q_cmd,
    input  logic                          q_empty,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [tsb_pkg::SLOT_W-1:0]    fired_slot,
    output logic                          still_armed,
    output logic                          last_of_run
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    localparam logic [tsb_pkg::IDX_W-1:0] LAST_IDX = tsb_pkg::IDX_W'(tsb_pkg::SLOT_CNT - 1);

    logic [tsb_pkg::PERIOD_W-1:0]    period_mem [tsb_pkg::SLOT_CNT];
    logic [tsb_pkg::TIME_W-1:0]      fire_mem   [tsb_pkg::SLOT_CNT];

    state_t                          state_reg,      state_next;
    logic [tsb_pkg::SLOT_CNT-1:0]    active_reg,     active_next;
    logic [tsb_pkg::SLOT_CNT-1:0]    periodic_reg,   periodic_next;
    logic [tsb_pkg::IDX_W-1:0]       idx_reg,        idx_next;
    logic [tsb_pkg::TIME_W-1:0]      now_reg,        now_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [tsb_pkg::IDX_W-1:0]       pend_slot_reg,  pend_slot_next;
    logic                            pend_armed_reg, pend_armed_next;
    logic                            out_valid_reg,  out_valid_next;
    logic [tsb_pkg::SLOT_W-1:0]      out_slot_reg,   out_slot_next;
    logic                            out_armed_reg,  out_armed_next;
    logic                            out_last_reg,   out_last_next;

    logic                            out_free;
    logic                            fire_hit;
    logic                            step;
    logic                            emit;
    logic                            emit_last;
    logic [tsb_pkg::IDX_W-1:0]       start_idx;
    logic                            period_we;
    logic                            fire_we;
    logic [tsb_pkg::IDX_W-1:0]       fire_addr;
    logic [tsb_pkg::TIME_W-1:0]      fire_data;

    assign out_free  = !out_valid_reg || pop;
    assign start_idx = tsb_pkg::IDX_W'(q_cmd.slot);
    assign fire_hit  = active_reg[idx_reg] && (fire_mem[idx_reg] < now_reg);
    assign step      = !(fire_hit && pend_valid_reg && !out_free);

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        periodic_next   = periodic_reg;
        idx_next        = idx_reg;
        now_next        = now_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_armed_next = pend_armed_reg;
        q_pop           = 1'b0;
        emit            = 1'b0;
        emit_last       = 1'b0;
        period_we       = 1'b0;
        fire_we         = 1'b0;
        fire_addr       = idx_reg;
        fire_data       = now_reg + tsb_pkg::TIME_W'(period_mem[idx_reg]);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.kind)
                        tsb_pkg::CMD_START:
                        begin
                            period_we                = 1'b1;
                            fire_we                  = 1'b1;
                            fire_addr                = start_idx;
                            fire_data                = q_cmd.now
                                                       + tsb_pkg::TIME_W'(q_cmd.period);
                            active_next[start_idx]   = 1'b1;
                            periodic_next[start_idx] = q_cmd.periodic;
                        end
                        tsb_pkg::CMD_STOP:
                        begin
                            active_next[start_idx] = 1'b0;
                        end
                        tsb_pkg::CMD_TICK:
                        begin
                            state_next = ST_SCAN;
                            idx_next   = '0;
                            now_next   = q_cmd.now;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (step)
                begin
                    if (fire_hit)
                    begin
                        // the previous hit is not the last one of this tick
                        emit            = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_slot_next  = idx_reg;
                        pend_armed_next = periodic_reg[idx_reg];
                        if (periodic_reg[idx_reg])
                        begin
                            fire_we = 1'b1;
                        end
                        else
                        begin
                            active_next[idx_reg] = 1'b0;
                        end
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = pend_valid_next ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    emit_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !pop;
        out_slot_next  = out_slot_reg;
        out_armed_next = out_armed_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_slot_next  = tsb_pkg::SLOT_W'(pend_slot_reg);
            out_armed_next = pend_armed_reg;
            out_last_next  = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= '0;
            periodic_reg   <= '0;
            idx_reg        <= '0;
            now_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_slot_reg  <= '0;
            pend_armed_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_slot_reg   <= '0;
            out_armed_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            periodic_reg   <= periodic_next;
            idx_reg        <= idx_next;
            now_reg        <= now_next;
            pend_valid_reg <= pend_valid_next;
            pend_slot_reg  <= pend_slot_next;
            pend_armed_reg <= pend_armed_next;
            out_valid_reg  <= out_valid_next;
            out_slot_reg   <= out_slot_next;
            out_armed_reg  <= out_armed_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (period_we)
        begin
            period_mem[start_idx] <= q_cmd.period;
        end
        if (fire_we)
        begin
            fire_mem[fire_addr] <= fire_data;
        end
    end

    assign empty       = !out_valid_reg;
    assign fired_slot  = out_slot_reg;
    assign still_armed = out_armed_reg;
    assign last_of_run = out_last_reg;

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending event left behind after scan");

    a_flush_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> pend_valid_reg)
        else $error("flush without a pending event");

    a_run_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (state_reg != ST_IDLE))
        else $error("run of events left without a closing event");

    a_oneshot_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && step && fire_hit && !periodic_reg[idx_reg])
        |=> !active_reg[$past(idx_reg)])
        else $error("one-shot slot still armed after firing");

endmodule

/* sv/timer_slot_bank.sv */
// channel   handshake     payload
// input     push / full   mode, slot, seconds, milliseconds, periodic, now
// result    empty / pop   fired_slot, still_armed, last_of_run
//
// start and stop requests pass the front register and the input queue before the slot updates
// a tick is dequeued, then scans one slot a cycle unless stalled; a flush state closes a run
// input queue of 4 requests lets the front keep taking requests while a scan runs
// a held result stalls the scan only when a second hit is found
// reset clears armed and periodic marks; period is written on start, fire time on start and periodic hits
module timer_slot_bank (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [tsb_pkg::MODE_W-1:0]        mode,
    input  logic [tsb_pkg::SLOT_W-1:0]        slot,
    input  logic [tsb_pkg::SEC_W-1:0]         seconds,
    input  logic [tsb_pkg::MSEC_W-1:0]        milliseconds,
    input  logic                              periodic,
    input  logic [tsb_pkg::TIME_W-1:0]        now,
    output logic                              empty,
    input  logic                              pop,
    output logic [tsb_pkg::SLOT_W-1:0]        fired_slot,
    output logic                              still_armed,
    output logic                              last_of_run
);

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    tsb_pkg::cmd_t    q_wr_cmd;
    tsb_pkg::cmd_t    q_rd_cmd;

    tsb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .slot         (slot),
        .seconds      (seconds),
        .milliseconds (milliseconds),
        .periodic     (periodic),
        .now          (now),
        .q_push       (q_push),
        .q_cmd        (q_wr_cmd),
        .q_full       (q_full)
    );

    tsb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_cmd),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_cmd),
        .empty   (q_empty)
    );

    tsb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_cmd       (q_rd_cmd),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .fired_slot  (fired_slot),
        .still_armed (still_armed),
        .last_of_run (last_of_run)
    );

endmodule
